FILE: hdl/kct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kct_pkg
// Shared types, codes and the micro-program of the constant-velocity tracker.
// ----------------------------------------------------------------------------
package kct_pkg;

  localparam int DT_FRAC = 16;
  localparam int PC_W    = 5;

  localparam logic [PC_W-1:0] PC_PRED_LAST = 5'd15;
  localparam logic [PC_W-1:0] PC_LAST      = 5'd29;

  localparam logic [1:0] REG_Q_ANGLE = 2'd0;
  localparam logic [1:0] REG_Q_CROSS = 2'd1;
  localparam logic [1:0] REG_Q_RATE  = 2'd2;
  localparam logic [1:0] REG_R_MEAS  = 2'd3;

  typedef struct packed {
    logic [15:0]        dt;
    logic signed [31:0] measurement;
    logic               has_measurement;
  } item_t;

  typedef struct packed {
    logic signed [31:0] pred_angle;
    logic signed [31:0] pred_rate;
    logic signed [31:0] post_angle;
    logic signed [31:0] post_rate;
    logic               saturated;
  } result_t;

  typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV} op_t;

  typedef enum logic [4:0] {
    SEL_ZERO, SEL_AE, SEL_RE, SEL_CAA, SEL_CAR, SEL_CRR, SEL_Z, SEL_QA,
    SEL_QC, SEL_QR, SEL_R, SEL_DT, SEL_PA, SEL_PR, SEL_U, SEL_AA,
    SEL_AR, SEL_RR, SEL_S, SEL_K1, SEL_K2, SEL_IN, SEL_T
  } sel_t;

  typedef struct packed {
    op_t  op;
    sel_t dst;
    sel_t a;
    sel_t b;
    logic frac;
  } cmd_t;

  typedef struct packed {
    logic load;
    logic go;
    logic emit;
    cmd_t cmd;
  } ctl_t;

  typedef struct packed {
    logic done;
    logic has_meas;
  } status_t;

  function automatic cmd_t mk(op_t op, sel_t dst, sel_t a, sel_t b, logic frac);
    cmd_t c;
    c.op   = op;
    c.dst  = dst;
    c.a    = a;
    c.b    = b;
    c.frac = frac;
    return c;
  endfunction

  function automatic cmd_t prog(logic [PC_W-1:0] pc);
    cmd_t c;
    case (pc)
      5'd0:    c = mk(OP_MUL, SEL_T,   SEL_RE,  SEL_DT,   1'b0);
      5'd1:    c = mk(OP_ADD, SEL_PA,  SEL_AE,  SEL_T,    1'b0);
      5'd2:    c = mk(OP_MUL, SEL_T,   SEL_CRR, SEL_DT,   1'b0);
      5'd3:    c = mk(OP_ADD, SEL_U,   SEL_CAR, SEL_T,    1'b0);
      5'd4:    c = mk(OP_MUL, SEL_T,   SEL_CAR, SEL_DT,   1'b0);
      5'd5:    c = mk(OP_ADD, SEL_AA,  SEL_CAA, SEL_T,    1'b0);
      5'd6:    c = mk(OP_MUL, SEL_T,   SEL_U,   SEL_DT,   1'b0);
      5'd7:    c = mk(OP_ADD, SEL_AA,  SEL_AA,  SEL_T,    1'b0);
      5'd8:    c = mk(OP_ADD, SEL_AA,  SEL_AA,  SEL_QA,   1'b0);
      5'd9:    c = mk(OP_ADD, SEL_AR,  SEL_U,   SEL_QC,   1'b0);
      5'd10:   c = mk(OP_ADD, SEL_RR,  SEL_CRR, SEL_QR,   1'b0);
      5'd11:   c = mk(OP_ADD, SEL_PR,  SEL_RE,  SEL_ZERO, 1'b0);
      5'd12:   c = mk(OP_ADD, SEL_AE,  SEL_PA,  SEL_ZERO, 1'b0);
      5'd13:   c = mk(OP_ADD, SEL_CAA, SEL_AA,  SEL_ZERO, 1'b0);
      5'd14:   c = mk(OP_ADD, SEL_CAR, SEL_AR,  SEL_ZERO, 1'b0);
      5'd15:   c = mk(OP_ADD, SEL_CRR, SEL_RR,  SEL_ZERO, 1'b0);
      5'd16:   c = mk(OP_ADD, SEL_S,   SEL_AA,  SEL_R,    1'b0);
      5'd17:   c = mk(OP_DIV, SEL_K1,  SEL_AA,  SEL_S,    1'b1);
      5'd18:   c = mk(OP_DIV, SEL_K2,  SEL_AR,  SEL_S,    1'b1);
      5'd19:   c = mk(OP_SUB, SEL_IN,  SEL_Z,   SEL_PA,   1'b0);
      5'd20:   c = mk(OP_MUL, SEL_T,   SEL_K1,  SEL_IN,   1'b1);
      5'd21:   c = mk(OP_ADD, SEL_AE,  SEL_PA,  SEL_T,    1'b0);
      5'd22:   c = mk(OP_MUL, SEL_T,   SEL_K2,  SEL_IN,   1'b1);
      5'd23:   c = mk(OP_ADD, SEL_RE,  SEL_PR,  SEL_T,    1'b0);
      5'd24:   c = mk(OP_MUL, SEL_T,   SEL_K1,  SEL_AA,   1'b1);
      5'd25:   c = mk(OP_SUB, SEL_CAA, SEL_AA,  SEL_T,    1'b0);
      5'd26:   c = mk(OP_MUL, SEL_T,   SEL_K1,  SEL_AR,   1'b1);
      5'd27:   c = mk(OP_SUB, SEL_CAR, SEL_AR,  SEL_T,    1'b0);
      5'd28:   c = mk(OP_MUL, SEL_T,   SEL_K2,  SEL_AR,   1'b1);
      5'd29:   c = mk(OP_SUB, SEL_CRR, SEL_RR,  SEL_T,    1'b0);
      default: c = mk(OP_ADD, SEL_T,   SEL_ZERO, SEL_ZERO, 1'b0);
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/kct_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kct_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface kct_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: hdl/kct_muldiv.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kct_muldiv
// Sequential signed multiply (8 bits a cycle) and divide (1 bit a cycle),
// rounded to nearest with ties away from zero and clipped to the word range.
// ----------------------------------------------------------------------------
module kct_muldiv #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic         is_div,
  input  wire logic         frac,
  input  wire logic [W:0]   a,
  input  wire logic [W:0]   b,
  output logic              done,
  output logic [W-1:0]      res,
  output logic              sat
);

  localparam int NDIG = (W + 7) / 8;
  localparam int PB   = 8 * NDIG;
  localparam int QW   = W + F;
  localparam int MW   = (2 * W > QW + 1) ? 2 * W : QW + 1;
  localparam int CNTW = $clog2(QW + 1);

  localparam logic [MW-1:0] HALF_F  = MW'(1) << (F - 1);
  localparam logic [MW-1:0] HALF_D  = MW'(1) << (kct_pkg::DT_FRAC - 1);
  localparam logic [MW-1:0] LIM_POS = (MW'(1) << (W - 1)) - MW'(1);
  localparam logic [MW-1:0] LIM_NEG = MW'(1) << (W - 1);
  localparam logic [W-1:0]  WMAX    = (W'(1) << (W - 1)) - W'(1);
  localparam logic [W-1:0]  WMIN    = W'(1) << (W - 1);

  typedef enum logic [2:0] {M_IDLE, M_MUL, M_DIV, M_RND, M_SAT} mstate_t;

  mstate_t          state;
  logic             neg;
  logic             div_op;
  logic             use_frac;
  logic [W-1:0]     ma;
  logic [PB-1:0]    mb;
  logic [MW-1:0]    acc;
  logic [QW-1:0]    nq;
  logic [W-1:0]     rem;
  logic [W-1:0]     d;
  logic [CNTW-1:0]  cnt;
  logic [MW-1:0]    mval;

  logic [W:0]       a_abs;
  logic [W:0]       b_abs;
  logic [W+7:0]     dig_prod;
  logic [W:0]       trial;
  logic             take;
  logic [MW-1:0]    rnd;
  logic [MW-1:0]    lim;

  assign a_abs    = a[W] ? (~a + (W+1)'(1)) : a;
  assign b_abs    = b[W] ? (~b + (W+1)'(1)) : b;
  assign dig_prod = (W+8)'(ma) * (W+8)'(mb[PB-1 -: 8]);
  assign trial    = {rem, nq[QW-1]};
  assign take     = trial >= {1'b0, d};
  assign rnd      = acc + (use_frac ? HALF_F : HALF_D);
  assign lim      = neg ? LIM_NEG : LIM_POS;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      case (state)
        M_IDLE: begin
          done <= start && is_div && (a == '0);
          if (start) begin
            neg      <= a[W] ^ b[W];
            div_op   <= is_div;
            use_frac <= frac;
            if (is_div) begin
              if (a == '0) begin
                res <= '0;
                sat <= 1'b0;
              end else begin
                nq    <= {a_abs[W-1:0], {F{1'b0}}};
                rem   <= '0;
                d     <= b_abs[W-1:0];
                cnt   <= CNTW'(QW);
                state <= M_DIV;
              end
            end else begin
              ma    <= a_abs[W-1:0];
              mb    <= PB'(b_abs[W-1:0]);
              acc   <= '0;
              cnt   <= CNTW'(NDIG);
              state <= M_MUL;
            end
          end
        end
        M_MUL: begin
          acc <= (acc << 8) + MW'(dig_prod);
          mb  <= mb << 8;
          cnt <= cnt - CNTW'(1);
          if (cnt == CNTW'(1)) begin
            state <= M_RND;
          end
        end
        M_DIV: begin
          rem <= take ? W'(trial - {1'b0, d}) : trial[W-1:0];
          nq  <= {nq[QW-2:0], take};
          cnt <= cnt - CNTW'(1);
          if (cnt == CNTW'(1)) begin
            state <= M_RND;
          end
        end
        M_RND: begin
          if (div_op) begin
            mval <= MW'(nq) + MW'(({rem, 1'b0} >= {1'b0, d}) ? 1 : 0);
          end else if (use_frac) begin
            mval <= rnd >> F;
          end else begin
            mval <= rnd >> kct_pkg::DT_FRAC;
          end
          state <= M_SAT;
        end
        M_SAT: begin
          if (mval > lim) begin
            sat <= 1'b1;
            res <= neg ? WMIN : WMAX;
          end else begin
            sat <= 1'b0;
            res <= neg ? (~mval[W-1:0] + W'(1)) : mval[W-1:0];
          end
          done  <= 1'b1;
          state <= M_IDLE;
        end
        default: begin
          done  <= 1'b0;
          state <= M_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hdl/kct_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kct_dp
// Datapath: state and scratch words, saturating adder, shared multiply and
// divide unit, result register.
// ----------------------------------------------------------------------------
module kct_dp #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire kct_pkg::ctl_t   ctl,
  input  wire kct_pkg::item_t  item,
  input  wire logic [30:0]     q_angle,
  input  wire logic [31:0]     q_cross,
  input  wire logic [30:0]     q_rate,
  input  wire logic [30:0]     r_meas,
  output kct_pkg::status_t     status,
  output kct_pkg::result_t     result
);

  localparam int CW = ((W > 33) ? W : 33) + 1;
  localparam logic [CW-1:0]  CMAX = (CW'(1) << (W - 1)) - CW'(1);
  localparam logic [CW-1:0]  CMIN = ~CMAX;
  localparam logic [W+2:0]   AMAX = ((W+3)'(1) << (W - 1)) - (W+3)'(1);
  localparam logic [W+2:0]   AMIN = ~AMAX;
  localparam logic [W-1:0]   ONE  = W'(1) << F;

  logic [W-1:0] ae, re, caa, car, crr;
  logic [W-1:0] z, qa, qc, qr, r;
  logic [15:0]  dt;
  logic [W-1:0] pa, pr, u, aa, ar, rr, s, k1, k2, innov, t;
  logic         has_meas;
  logic         sat_acc;
  logic         add_done;

  logic [W:0]   opa, opb;
  logic [W+2:0] sum;
  logic         add_sat;
  logic [W-1:0] add_val;
  logic         is_add;
  logic         md_done;
  logic [W-1:0] md_res;
  logic         md_sat;
  logic         wr_en;
  logic [W-1:0] wr_val;
  logic         wr_sat;
  logic [W:0]   cz, cqa, cqc, cqr, cr;

  function automatic logic [W:0] clip_in(logic [32:0] v);
    logic [CW-1:0] e;
    e = {{(CW-33){v[32]}}, v};
    if ($signed(e) > $signed(CMAX)) begin
      return {1'b1, CMAX[W-1:0]};
    end else if ($signed(e) < $signed(CMIN)) begin
      return {1'b1, CMIN[W-1:0]};
    end
    return {1'b0, e[W-1:0]};
  endfunction

  function automatic logic [31:0] to32(logic [W-1:0] v);
    logic [CW-1:0] e;
    e = {{(CW-W){v[W-1]}}, v};
    return e[31:0];
  endfunction

  function automatic logic [W:0] ext(logic [W-1:0] v);
    return {v[W-1], v};
  endfunction

  function automatic logic [W:0] rd(kct_pkg::sel_t sel);
    logic [W:0] v;
    case (sel)
      kct_pkg::SEL_AE:  v = ext(ae);
      kct_pkg::SEL_RE:  v = ext(re);
      kct_pkg::SEL_CAA: v = ext(caa);
      kct_pkg::SEL_CAR: v = ext(car);
      kct_pkg::SEL_CRR: v = ext(crr);
      kct_pkg::SEL_Z:   v = ext(z);
      kct_pkg::SEL_QA:  v = ext(qa);
      kct_pkg::SEL_QC:  v = ext(qc);
      kct_pkg::SEL_QR:  v = ext(qr);
      kct_pkg::SEL_R:   v = ext(r);
      kct_pkg::SEL_DT:  v = (W+1)'(dt);
      kct_pkg::SEL_PA:  v = ext(pa);
      kct_pkg::SEL_PR:  v = ext(pr);
      kct_pkg::SEL_U:   v = ext(u);
      kct_pkg::SEL_AA:  v = ext(aa);
      kct_pkg::SEL_AR:  v = ext(ar);
      kct_pkg::SEL_RR:  v = ext(rr);
      kct_pkg::SEL_S:   v = ext(s);
      kct_pkg::SEL_K1:  v = ext(k1);
      kct_pkg::SEL_K2:  v = ext(k2);
      kct_pkg::SEL_IN:  v = ext(innov);
      kct_pkg::SEL_T:   v = ext(t);
      default:          v = '0;
    endcase
    return v;
  endfunction

  assign opa = rd(ctl.cmd.a);
  assign opb = rd(ctl.cmd.b);

  always_comb begin
    if (ctl.cmd.op == kct_pkg::OP_SUB) begin
      sum = {{2{opa[W]}}, opa} - {{2{opb[W]}}, opb};
    end else begin
      sum = {{2{opa[W]}}, opa} + {{2{opb[W]}}, opb};
    end
    if ($signed(sum) > $signed(AMAX)) begin
      add_sat = 1'b1;
      add_val = AMAX[W-1:0];
    end else if ($signed(sum) < $signed(AMIN)) begin
      add_sat = 1'b1;
      add_val = AMIN[W-1:0];
    end else begin
      add_sat = 1'b0;
      add_val = sum[W-1:0];
    end
  end

  assign is_add = (ctl.cmd.op == kct_pkg::OP_ADD) || (ctl.cmd.op == kct_pkg::OP_SUB);

  kct_muldiv #(.W(W), .F(F)) u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .start  (ctl.go && !is_add),
    .is_div (ctl.cmd.op == kct_pkg::OP_DIV),
    .frac   (ctl.cmd.frac),
    .a      (opa),
    .b      (opb),
    .done   (md_done),
    .res    (md_res),
    .sat    (md_sat)
  );

  assign wr_en  = (ctl.go && is_add) || md_done;
  assign wr_val = md_done ? md_res : add_val;
  assign wr_sat = md_done ? md_sat : add_sat;

  assign cz  = clip_in({item.measurement[31], item.measurement});
  assign cqa = clip_in({2'b00, q_angle});
  assign cqc = clip_in({q_cross[31], q_cross});
  assign cqr = clip_in({2'b00, q_rate});
  assign cr  = clip_in({2'b00, r_meas});

  assign status.done     = add_done || md_done;
  assign status.has_meas = has_meas;

  always_ff @(posedge clk) begin
    if (rst) begin
      ae       <= '0;
      re       <= '0;
      caa      <= ONE;
      car      <= '0;
      crr      <= ONE;
      add_done <= 1'b0;
      sat_acc  <= 1'b0;
      has_meas <= 1'b0;
    end else begin
      add_done <= ctl.go && is_add;
      if (ctl.load) begin
        z        <= cz[W-1:0];
        qa       <= cqa[W-1:0];
        qc       <= cqc[W-1:0];
        qr       <= cqr[W-1:0];
        r        <= cr[W-1:0];
        dt       <= item.dt;
        has_meas <= item.has_measurement;
        sat_acc  <= cz[W] | cqa[W] | cqc[W] | cqr[W] | cr[W];
      end else if (wr_en) begin
        sat_acc <= sat_acc | wr_sat;
        case (ctl.cmd.dst)
          kct_pkg::SEL_AE:  ae    <= wr_val;
          kct_pkg::SEL_RE:  re    <= wr_val;
          kct_pkg::SEL_CAA: caa   <= wr_val;
          kct_pkg::SEL_CAR: car   <= wr_val;
          kct_pkg::SEL_CRR: crr   <= wr_val;
          kct_pkg::SEL_PA:  pa    <= wr_val;
          kct_pkg::SEL_PR:  pr    <= wr_val;
          kct_pkg::SEL_U:   u     <= wr_val;
          kct_pkg::SEL_AA:  aa    <= wr_val;
          kct_pkg::SEL_AR:  ar    <= wr_val;
          kct_pkg::SEL_RR:  rr    <= wr_val;
          kct_pkg::SEL_S:   s     <= wr_val;
          kct_pkg::SEL_K1:  k1    <= wr_val;
          kct_pkg::SEL_K2:  k2    <= wr_val;
          kct_pkg::SEL_IN:  innov <= wr_val;
          kct_pkg::SEL_T:   t     <= wr_val;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      result.pred_angle <= to32(pa);
      result.pred_rate  <= to32(pr);
      result.post_angle <= to32(ae);
      result.post_rate  <= to32(re);
      result.saturated  <= sat_acc;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/kct_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kct_ctrl
// Controller: accepts an item, steps the micro-program, hands the result to
// the output register.
// ----------------------------------------------------------------------------
module kct_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire kct_pkg::status_t  status,
  output kct_pkg::ctl_t          ctl
);

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_EMIT} state_t;

  state_t                       state;
  logic [kct_pkg::PC_W-1:0]     pc;
  logic                         last;

  assign in_ready = (state == S_IDLE);
  assign ctl.load = in_valid && in_ready;
  assign ctl.go   = (state == S_ISSUE);
  assign ctl.emit = (state == S_EMIT) && (!out_valid || out_ready);
  assign ctl.cmd  = kct_pkg::prog(pc);
  assign last     = (pc == kct_pkg::PC_LAST) ||
                    ((pc == kct_pkg::PC_PRED_LAST) && !status.has_meas);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (ctl.load) begin
            pc    <= '0;
            state <= S_ISSUE;
          end
        end
        S_ISSUE: state <= S_WAIT;
        S_WAIT: begin
          if (status.done) begin
            if (last) begin
              state <= S_EMIT;
            end else begin
              pc    <= pc + kct_pkg::PC_W'(1);
              state <= S_ISSUE;
            end
          end
        end
        S_EMIT: begin
          if (ctl.emit) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hdl/kalman_cv_track_2state_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kalman_cv_track_2state_top
// Two-state constant-velocity Kalman tracker with APB register port.
// Each item runs the predict steps, and with a measurement the update steps
// too; multiplies go 8 bits a cycle and gain divides 1 bit a cycle. A new
// item is taken only once the last one is done, but the next item is taken
// while a result waits.
// Reset: synchronous; state and covariance return to zero and identity.
// ----------------------------------------------------------------------------
module kalman_cv_track_2state_top #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  kct_stream_if.sink       item,
  kct_stream_if.source     result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [30:0]       q_angle;
  logic [31:0]       q_cross;
  logic [30:0]       q_rate;
  logic [30:0]       r_meas;
  kct_pkg::ctl_t     ctl;
  kct_pkg::status_t  status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_angle <= 31'd655;
      q_cross <= 32'd0;
      q_rate  <= 31'd655;
      r_meas  <= 31'd65536;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        kct_pkg::REG_Q_ANGLE: q_angle <= pwdata[30:0];
        kct_pkg::REG_Q_CROSS: q_cross <= pwdata;
        kct_pkg::REG_Q_RATE:  q_rate  <= pwdata[30:0];
        kct_pkg::REG_R_MEAS:  r_meas  <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      kct_pkg::REG_Q_ANGLE: prdata = {1'b0, q_angle};
      kct_pkg::REG_Q_CROSS: prdata = q_cross;
      kct_pkg::REG_Q_RATE:  prdata = {1'b0, q_rate};
      kct_pkg::REG_R_MEAS:  prdata = {1'b0, r_meas};
      default:              prdata = '0;
    endcase
  end

  kct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .ctl       (ctl)
  );

  kct_dp #(.W(WORD_BITS), .F(FRAC_BITS)) u_dp (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .item    (item.payload),
    .q_angle (q_angle),
    .q_cross (q_cross),
    .q_rate  (q_rate),
    .r_meas  (r_meas),
    .status  (status),
    .result  (result.payload)
  );

endmodule
`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the constant-velocity angle/rate tracker. Walks a
// short table of items, then several register settings under random idling,
// and checks every result against an in-bench fixed-point model of the filter or a row's given result.
// ----------------------------------------------------------------------------
module testbench;

  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  kct_stream_if #(.payload_t(kct_pkg::item_t)) item_ch ();
  kct_stream_if #(.payload_t(kct_pkg::result_t)) result_ch ();

  kalman_cv_track_2state_top dut (
    .clk(clk), .rst(rst), .item(item_ch.sink), .result(result_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  longint trk_angle, trk_rate, cov_aa, cov_ar, cov_rr;
  longint q_angle, q_cross, q_rate, r_meas;
  bit clipped;
  kct_pkg::result_t tracks_due[$];
  int mismatches = 0;
  int results_seen = 0;
  int items_sent = 0;
  int meas_sent = 0;
  int stall_cycles = 0;
  int tx_idle = 0;
  int rx_idle = 0;

  function automatic longint sat_word(longint x);
    if (x > WMAX) begin
      clipped = 1'b1;
      return WMAX;
    end
    if (x < WMIN) begin
      clipped = 1'b1;
      return WMIN;
    end
    return x;
  endfunction

  function automatic longint from_mag(bit neg, longint unsigned v);
    longint unsigned lim;
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    if (v > lim) begin
      clipped = 1'b1;
      return neg ? WMIN : WMAX;
    end
    return neg ? -longint'(v) : longint'(v);
  endfunction

  function automatic longint unsigned mag(longint x);
    return x < 0 ? longint'(-x) : x;
  endfunction

  function automatic longint fx_mul(longint a, longint b, int sh);
    longint unsigned p;
    p = mag(a) * mag(b) + (64'd1 << (sh - 1));
    return from_mag((a < 0) != (b < 0), p >> sh);
  endfunction

  function automatic longint gain_div(longint num, longint den);
    longint unsigned nn, d, q, rem;
    if (num == 0) return 0;
    if (den == 0) begin
      clipped = 1'b1;
      return num < 0 ? WMIN : WMAX;
    end
    nn = mag(num) << 16;
    d = mag(den);
    q = nn / d;
    rem = nn % d;
    if (rem * 2 >= d) q++;
    return from_mag((num < 0) != (den < 0), q);
  endfunction

  function automatic kct_pkg::result_t track_step(kct_pkg::item_t it);
    longint dt, z, pa, pr, u, aa, ar, rr, s, k1, k2, innov;
    kct_pkg::result_t r;
    clipped = 1'b0;
    dt = longint'(it.dt);
    z = longint'(it.measurement);
    pa = sat_word(trk_angle + fx_mul(trk_rate, dt, kct_pkg::DT_FRAC));
    pr = trk_rate;
    u = sat_word(cov_ar + fx_mul(cov_rr, dt, kct_pkg::DT_FRAC));
    aa = sat_word(cov_aa + fx_mul(cov_ar, dt, kct_pkg::DT_FRAC));
    aa = sat_word(aa + fx_mul(u, dt, kct_pkg::DT_FRAC));
    aa = sat_word(aa + q_angle);
    ar = sat_word(u + q_cross);
    rr = sat_word(cov_rr + q_rate);
    trk_angle = pa;
    trk_rate = pr;
    cov_aa = aa;
    cov_ar = ar;
    cov_rr = rr;
    if (it.has_measurement) begin
      s = sat_word(aa + r_meas);
      k1 = gain_div(aa, s);
      k2 = gain_div(ar, s);
      innov = sat_word(z - pa);
      trk_angle = sat_word(pa + fx_mul(k1, innov, 16));
      trk_rate = sat_word(pr + fx_mul(k2, innov, 16));
      cov_aa = sat_word(aa - fx_mul(k1, aa, 16));
      cov_ar = sat_word(ar - fx_mul(k1, ar, 16));
      cov_rr = sat_word(rr - fx_mul(k2, ar, 16));
    end
    r.pred_angle = pa[31:0];
    r.pred_rate = pr[31:0];
    r.post_angle = trk_angle[31:0];
    r.post_rate = trk_rate[31:0];
    r.saturated = clipped;
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch on result %0d: %s got %0d expected %0d",
             results_seen, field, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    kct_pkg::result_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (tracks_due.size() == 0) begin
          report_mismatch("unexpected transaction", 1, 0);
        end else begin
          want = tracks_due.pop_front();
          if (result_ch.payload.pred_angle !== want.pred_angle)
            report_mismatch("pred_angle", result_ch.payload.pred_angle, want.pred_angle);
          if (result_ch.payload.pred_rate !== want.pred_rate)
            report_mismatch("pred_rate", result_ch.payload.pred_rate, want.pred_rate);
          if (result_ch.payload.post_angle !== want.post_angle)
            report_mismatch("post_angle", result_ch.payload.post_angle, want.post_angle);
          if (result_ch.payload.post_rate !== want.post_rate)
            report_mismatch("post_rate", result_ch.payload.post_rate, want.post_rate);
          if (result_ch.payload.saturated !== want.saturated)
            report_mismatch("saturated", result_ch.payload.saturated, want.saturated);
        end
        results_seen++;
      end
      result_ch.ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles > STALL_LIMIT) begin
      $display("watchdog expired, %0d results outstanding", tracks_due.size());
      $display("FAIL kalman_cv_track_2state_top");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      kct_pkg::REG_Q_ANGLE: q_angle = longint'(value[30:0]);
      kct_pkg::REG_Q_CROSS: q_cross = longint'(signed'(value));
      kct_pkg::REG_Q_RATE:  q_rate = longint'(value[30:0]);
      kct_pkg::REG_R_MEAS:  r_meas = longint'(value[30:0]);
      default: ;
    endcase
  endtask

  task automatic drain();
    while (tracks_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // valid stays high across back-to-back transactions; lower it only on a gap
  task automatic send_item(kct_pkg::item_t it, bit typed, kct_pkg::result_t typed_res);
    kct_pkg::result_t want;
    bit lowered;
    lowered = 1'b0;
    while ($urandom_range(99) < tx_idle) begin
      if (!lowered) item_ch.valid <= 1'b0;
      lowered = 1'b1;
      @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.payload <= it;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    want = track_step(it);
    tracks_due.push_back(typed ? typed_res : want);
    items_sent++;
    if (it.has_measurement) meas_sent++;
  endtask

  function automatic kct_pkg::item_t random_item();
    kct_pkg::item_t it;
    longint m;
    it.dt = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(6554));
    if ($urandom_range(9) == 0) begin
      it.measurement = $urandom;
    end else begin
      m = trk_angle + longint'($urandom_range(524288)) - 262144;
      if (m > WMAX) m = WMAX;
      if (m < WMIN) m = WMIN;
      it.measurement = m[31:0];
    end
    it.has_measurement = ($urandom_range(4) != 0);
    return it;
  endfunction

  typedef struct {
    kct_pkg::item_t   it;
    bit               typed;
    kct_pkg::result_t res;
  } row_t;

  row_t walk[] = '{
    '{'{16'd0, 32'sd0, 1'b0}, 1'b1, '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0}},
    '{'{16'hffff, 32'sd0, 1'b1}, 1'b1, '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0}},
    '{'{16'hffff, 32'h7fffffff, 1'b1}, 1'b0, '0},
    '{'{16'd1, 32'h80000000, 1'b1}, 1'b0, '0},
    '{'{16'hffff, 32'h7fffffff, 1'b0}, 1'b0, '0},
    '{'{16'h8000, 32'h00010000, 1'b1}, 1'b0, '0},
    '{'{16'd0, 32'hffff0000, 1'b1}, 1'b0, '0},
    '{'{16'h1999, 32'h55555555, 1'b1}, 1'b0, '0},
    '{'{16'h1999, 32'haaaaaaaa, 1'b1}, 1'b0, '0},
    '{'{16'h0001, 32'h00000000, 1'b0}, 1'b0, '0},
    '{'{16'hffff, 32'h80000000, 1'b1}, 1'b0, '0},
    '{'{16'h7fff, 32'h7fffffff, 1'b1}, 1'b0, '0}
  };

  logic [31:0] settings [9][4] = '{
    '{32'd655, 32'd0, 32'd655, 32'd65536},
    '{32'd0, 32'd0, 32'd0, 32'd0},
    '{32'd0, 32'd1000, 32'd0, 32'd0},
    '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff},
    '{32'd0, 32'h80000000, 32'd0, 32'd1},
    '{32'd3277, 32'hfffff000, 32'd1311, 32'd6554},
    '{32'h80000010, 32'd500, 32'h80000020, 32'h80020000},
    '{32'd20, 32'd0, 32'd20, 32'd300000},
    '{32'd0, 32'd0, 32'd0, 32'd0}
  };

  initial begin
    kct_pkg::result_t none;
    none = '0;
    item_ch.valid = 1'b0;
    item_ch.payload = '0;
    trk_angle = 0;
    trk_rate = 0;
    cov_aa = 65536;
    cov_ar = 0;
    cov_rr = 65536;
    q_angle = 655;
    q_cross = 0;
    q_rate = 655;
    r_meas = 65536;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (walk[i]) send_item(walk[i].it, walk[i].typed, walk[i].res);
    for (int ph = 0; ph < 9; ph++) begin
      item_ch.valid <= 1'b0;
      drain();
      for (int k = 0; k < 4; k++)
        write_reg(k[1:0], (ph >= 5 && k == 1) ? $urandom : settings[ph][k]);
      tx_idle = (ph < 3) ? 6 : (ph < 6) ? 88 : 0;
      rx_idle = (ph < 3) ? 88 : (ph < 6) ? 6 : 0;
      for (int n = 0; n < 222; n++) send_item(random_item(), 1'b0, none);
    end
    item_ch.valid <= 1'b0;
    drain();
    $display("%0d items sent, %0d with a measurement, %0d results checked",
             items_sent, meas_sent, results_seen);
    $display("9 register settings including zero and full-scale noise terms");
    if (mismatches == 0 && tracks_due.size() == 0) begin
      $display("PASS kalman_cv_track_2state_top");
    end else begin
      $display("FAIL kalman_cv_track_2state_top");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/kct_pkg.sv
hdl/kct_stream_if.sv
hdl/kct_muldiv.sv
hdl/kct_dp.sv
hdl/kct_ctrl.sv
hdl/kalman_cv_track_2state_top.sv
bench/testbench.sv
